### hdl/pulse_width_frame_transceiver_macros.svh
// Assertion macros for the pulse-width link RTL.
`ifndef PULSE_WIDTH_FRAME_TRANSCEIVER_MACROS_SVH
`define PULSE_WIDTH_FRAME_TRANSCEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PWFX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwfx check failed");

// Next-cycle implication, checked out of reset.
`define PWFX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwfx check failed");

`endif

### hdl/pwfx_pkg.sv
// Types and constants of the pulse-width link transceiver.
package pwfx_pkg;

  localparam int FRAME_BYTES = 3;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int WIDTH_BITS  = 16;
  localparam int BIT_IDX_W   = $clog2(FRAME_BITS);
  localparam int SLOT_CNT_W  = 7;
  localparam int RX_IDX_W    = 8;
  localparam int STOP_SLOTS  = 3;
  localparam int STOP_HOLD   = 1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_WIDTH = 2'd2,
    MODE_RECV  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_PREAMBLE_PAIRS = 3'd0,
    REG_HEADER_SLOTS   = 3'd1,
    REG_BIT1_MIN       = 3'd2,
    REG_BIT1_MAX       = 3'd3,
    REG_BIT0_MIN       = 3'd4,
    REG_BIT0_MAX       = 3'd5,
    REG_SKIP_WIDTHS    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RX_OK        = 2'd0,
    RX_BAD_WIDTH = 2'd1,
    RX_BAD_SUM   = 2'd2
  } rx_status_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_PRE  = 5'b00010,
    PH_HDR  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_STOP = 5'b10000
  } tx_phase_e;

  typedef struct packed {
    logic [4:0] preamble_pairs;
    logic [5:0] header_slots;
  } tx_cfg_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] bit1_min;
    logic [WIDTH_BITS-1:0] bit1_max;
    logic [WIDTH_BITS-1:0] bit0_min;
    logic [WIDTH_BITS-1:0] bit0_max;
    logic [6:0]            skip;
  } rx_cfg_t;

  typedef struct packed {
    logic       is_reply;
    logic       toggle_line;
    logic       tx_last;
    logic [7:0] reply_first;
    logic [7:0] reply_second;
    rx_status_e rx_status;
  } res_t;

endpackage

### hdl/pwfx_tx.sv
// Transmit slot sequencer: preamble, header gap, coded data bits, stop slots.
module pwfx_tx import pwfx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic       tick_i,
  input  logic [7:0] first_byte_i,
  input  logic [7:0] second_byte_i,
  input  tx_cfg_t    cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  tx_phase_e               phase_q, phase_d;
  logic [SLOT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]              sub_q, sub_d;
  logic [BIT_IDX_W-1:0]    bit_q, bit_d;
  logic [FRAME_BITS-1:0]   shift_q, shift_d;

  tx_phase_e               mid_phase, eff_phase;
  logic [SLOT_CNT_W-1:0]   mid_cnt, eff_cnt;
  logic                    pre_done, hdr_done;
  logic                    tog, last;

  // Skip phases that are empty or already complete.
  always_comb begin
    pre_done  = (phase_q == PH_PRE) &&
                (cnt_q >= {1'b0, cfg_i.preamble_pairs, 1'b0});
    mid_phase = pre_done ? PH_HDR : phase_q;
    mid_cnt   = pre_done ? '0 : cnt_q;
    hdr_done  = (mid_phase == PH_HDR) && (mid_cnt >= {1'b0, cfg_i.header_slots});
    eff_phase = hdr_done ? PH_DATA : mid_phase;
    eff_cnt   = hdr_done ? '0 : mid_cnt;
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    sub_d       = sub_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    tog         = 1'b0;
    last        = 1'b0;
    res_valid_o = 1'b0;
    if (load_i) begin
      shift_d = {first_byte_i ^ second_byte_i, second_byte_i, first_byte_i};
      phase_d = PH_PRE;
      cnt_d   = '0;
      sub_d   = '0;
      bit_d   = '0;
    end else if (tick_i) begin
      phase_d     = eff_phase;
      cnt_d       = eff_cnt;
      res_valid_o = 1'b1;
      unique case (eff_phase)
        PH_PRE: begin
          tog   = 1'b1;
          cnt_d = eff_cnt + SLOT_CNT_W'(1);
        end
        PH_HDR: begin
          cnt_d = eff_cnt + SLOT_CNT_W'(1);
        end
        PH_DATA: begin
          unique case (sub_q)
            2'd0:    tog = 1'b1;
            2'd1:    tog = shift_q[0];
            default: tog = ~shift_q[0];
          endcase
          if (sub_q == 2'd2) begin
            shift_d = shift_q >> 1;
            sub_d   = '0;
            if (bit_q == BIT_IDX_W'(FRAME_BITS - 1)) begin
              phase_d = PH_STOP;
              cnt_d   = '0;
              bit_d   = '0;
            end else begin
              bit_d = bit_q + BIT_IDX_W'(1);
            end
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
        PH_STOP: begin
          tog   = (eff_cnt != SLOT_CNT_W'(STOP_HOLD));
          cnt_d = eff_cnt + SLOT_CNT_W'(1);
          if (eff_cnt == SLOT_CNT_W'(STOP_SLOTS - 1)) begin
            last    = 1'b1;
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end
        end
        default: begin
          phase_d     = PH_IDLE;
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res_o              = '0;
    res_o.is_reply     = 1'b0;
    res_o.toggle_line  = tog;
    res_o.tx_last      = last;
    res_o.rx_status    = RX_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      sub_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
    end
  end

endmodule

### hdl/pwfx_rx.sv
// Receive decoder: skips leading widths, classes 24 widths, checks the XOR byte.
module pwfx_rx import pwfx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  width_i,
  input  logic [WIDTH_BITS-1:0] pulse_width_i,
  input  rx_cfg_t               cfg_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  logic                  active_q, active_d;
  logic [RX_IDX_W-1:0]   idx_q, idx_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;

  logic                  in_skip;
  logic [RX_IDX_W-1:0]   pos_full;
  logic [BIT_IDX_W-1:0]  pos;
  logic                  is_one, is_zero, at_end;
  logic [FRAME_BITS-1:0] shift_new;

  always_comb begin
    in_skip   = idx_q < {1'b0, cfg_i.skip};
    pos_full  = idx_q - {1'b0, cfg_i.skip};
    // A position past the last bit counts as the last bit.
    pos       = (pos_full > RX_IDX_W'(FRAME_BITS - 1)) ?
                BIT_IDX_W'(FRAME_BITS - 1) : pos_full[BIT_IDX_W-1:0];
    at_end    = (pos == BIT_IDX_W'(FRAME_BITS - 1));
    is_one    = (pulse_width_i >= cfg_i.bit1_min) && (pulse_width_i <= cfg_i.bit1_max);
    is_zero   = (pulse_width_i >= cfg_i.bit0_min) && (pulse_width_i <= cfg_i.bit0_max);
    shift_new = shift_q | (is_one ? (FRAME_BITS'(1) << pos) : '0);
  end

  always_comb begin
    active_d    = active_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.is_reply  = 1'b1;
    res_o.rx_status = RX_OK;
    if (start_i) begin
      active_d = 1'b1;
      idx_d    = '0;
      shift_d  = '0;
    end else if (width_i && active_q) begin
      if (in_skip) begin
        idx_d = idx_q + RX_IDX_W'(1);
      end else if (!is_one && !is_zero) begin
        active_d        = 1'b0;
        res_valid_o     = 1'b1;
        res_o.rx_status = RX_BAD_WIDTH;
      end else begin
        shift_d = shift_new;
        idx_d   = idx_q + RX_IDX_W'(1);
        if (at_end) begin
          active_d    = 1'b0;
          res_valid_o = 1'b1;
          if ((shift_new[7:0] ^ shift_new[15:8] ^ shift_new[23:16]) != 8'd0) begin
            res_o.rx_status = RX_BAD_SUM;
          end else begin
            res_o.reply_first  = shift_new[7:0];
            res_o.reply_second = shift_new[15:8];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      shift_q  <= '0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      shift_q  <= shift_d;
    end
  end

endmodule

### hdl/pulse_width_frame_transceiver.sv
// Pulse-width link transceiver: each input beat passes the input register, then the
// result register; one item per cycle while the result register is not stalled.
// The slot sequencer and width classifier work combinationally, both placed
// between the input register and the result register.
// Reset (rst_ni low, asynchronous) idles transmit and receive, empties both
// registers and restores the configuration registers to their defaults.
`include "pulse_width_frame_transceiver_macros.svh"

module pulse_width_frame_transceiver import pwfx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic [7:0]            first_byte_i,
  input  logic [7:0]            second_byte_i,
  input  logic [WIDTH_BITS-1:0] pulse_width_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  is_reply_o,
  output logic                  toggle_line_o,
  output logic                  tx_last_o,
  output logic [7:0]            reply_first_o,
  output logic [7:0]            reply_second_o,
  output logic [1:0]            rx_status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  tx_cfg_t tx_cfg_q;
  rx_cfg_t rx_cfg_q;

  logic                  s1_valid_q;
  mode_e                 s1_mode_q;
  logic [7:0]            s1_first_q, s1_second_q;
  logic [WIDTH_BITS-1:0] s1_width_q;

  logic                  out_valid_q;
  res_t                  out_q;

  logic in_fire, advance, fire;
  logic tx_valid, rx_valid;
  res_t tx_res, rx_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cfg_q.preamble_pairs <= 5'd8;
      tx_cfg_q.header_slots   <= 6'd4;
      rx_cfg_q.bit1_min       <= '0;
      rx_cfg_q.bit1_max       <= '0;
      rx_cfg_q.bit0_min       <= '0;
      rx_cfg_q.bit0_max       <= '0;
      rx_cfg_q.skip           <= 7'd20;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PREAMBLE_PAIRS: tx_cfg_q.preamble_pairs <= cfg_data_i[4:0];
        REG_HEADER_SLOTS:   tx_cfg_q.header_slots   <= cfg_data_i[5:0];
        REG_BIT1_MIN:       rx_cfg_q.bit1_min       <= cfg_data_i[WIDTH_BITS-1:0];
        REG_BIT1_MAX:       rx_cfg_q.bit1_max       <= cfg_data_i[WIDTH_BITS-1:0];
        REG_BIT0_MIN:       rx_cfg_q.bit0_min       <= cfg_data_i[WIDTH_BITS-1:0];
        REG_BIT0_MAX:       rx_cfg_q.bit0_max       <= cfg_data_i[WIDTH_BITS-1:0];
        REG_SKIP_WIDTHS:    rx_cfg_q.skip           <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Input register advances whenever the result register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q   <= mode_e'(mode_i);
      s1_first_q  <= first_byte_i;
      s1_second_q <= second_byte_i;
      s1_width_q  <= pulse_width_i;
    end
  end

  pwfx_tx u_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire && (s1_mode_q == MODE_LOAD)),
    .tick_i        (fire && (s1_mode_q == MODE_TICK)),
    .first_byte_i  (s1_first_q),
    .second_byte_i (s1_second_q),
    .cfg_i         (tx_cfg_q),
    .res_valid_o   (tx_valid),
    .res_o         (tx_res)
  );

  pwfx_rx u_rx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (fire && (s1_mode_q == MODE_RECV)),
    .width_i       (fire && (s1_mode_q == MODE_WIDTH)),
    .pulse_width_i (s1_width_q),
    .cfg_i         (rx_cfg_q),
    .res_valid_o   (rx_valid),
    .res_o         (rx_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= tx_valid || rx_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rx_valid ? rx_res : tx_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_reply_o     = out_q.is_reply;
  assign toggle_line_o  = out_q.toggle_line;
  assign tx_last_o      = out_q.tx_last;
  assign reply_first_o  = out_q.reply_first;
  assign reply_second_o = out_q.reply_second;
  assign rx_status_o    = out_q.rx_status;

  `PWFX_ASSERT_NOW(a_one_source, clk_i, rst_ni, 1'b1, !(tx_valid && rx_valid))
  `PWFX_ASSERT_NOW(a_stall_needs_item, clk_i, rst_ni, in_stall_o, s1_valid_q)
  `PWFX_ASSERT_NOW(a_error_no_bytes, clk_i, rst_ni, rx_valid && (rx_res.rx_status != RX_OK),
                   (rx_res.reply_first == 8'd0) && (rx_res.reply_second == 8'd0))
  `PWFX_ASSERT_NEXT(a_held_result, clk_i, rst_ni, out_valid_q && out_stall_i,
                    out_valid_q && $stable(out_q))

endmodule

### dv/tb_pulse_width_frame_transceiver.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pulse-width link transceiver: directed and mixed random traffic.
module tb_pulse_width_frame_transceiver;
  import pwfx_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RST_CYCLES      = 5;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_ITEMS    = 800;
  localparam int RANDOM_PHASES   = 10;
  localparam int REPORT_MAX      = 10;
  localparam int DATA_SLOTS      = 3 * FRAME_BITS;
  localparam int LAST_BIT        = FRAME_BITS - 1;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            mode_i;
  logic [7:0]            first_byte_i;
  logic [7:0]            second_byte_i;
  logic [WIDTH_BITS-1:0] pulse_width_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  is_reply_o;
  logic                  toggle_line_o;
  logic                  tx_last_o;
  logic [7:0]            reply_first_o;
  logic [7:0]            reply_second_o;
  logic [1:0]            rx_status_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i;
  logic [15:0]           cfg_data_i;

  pulse_width_frame_transceiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .first_byte_i   (first_byte_i),
    .second_byte_i  (second_byte_i),
    .pulse_width_i  (pulse_width_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_reply_o     (is_reply_o),
    .toggle_line_o  (toggle_line_o),
    .tx_last_o      (tx_last_o),
    .reply_first_o  (reply_first_o),
    .reply_second_o (reply_second_o),
    .rx_status_o    (rx_status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Expected slot and reply beats, oldest first.
  res_t        pending_results[$];
  // Widths still to feed for the reception in flight.
  logic [15:0] rx_plan_q[$];

  // Shadow configuration.
  logic [4:0]  cfg_pairs;
  logic [5:0]  cfg_hdr;
  logic [15:0] one_lo, one_hi, zero_lo, zero_hi;
  logic [6:0]  cfg_skip;

  // Shadow transmit and receive state.
  logic [23:0] tx_bits;
  tx_phase_e   tx_ph;
  logic [6:0]  tx_cnt;
  logic [23:0] rx_bits;
  logic [7:0]  rx_idx;
  logic        rx_on;

  int mismatch_cnt;
  int failure_cnt;
  int effective_items;
  int quiet_cycles;
  bit send_gaps_on;
  bit rcv_gaps_on;
  bit hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit fits_one(logic [15:0] w);
    return w >= one_lo && w <= one_hi;
  endfunction

  function automatic bit fits_zero(logic [15:0] w);
    return w >= zero_lo && w <= zero_hi;
  endfunction

  task automatic reset_predictor();
    cfg_pairs = 5'd8;
    cfg_hdr   = 6'd4;
    one_lo    = '0;
    one_hi    = '0;
    zero_lo   = '0;
    zero_hi   = '0;
    cfg_skip  = 7'd20;
    tx_bits   = '0;
    tx_ph     = PH_IDLE;
    tx_cnt    = '0;
    rx_bits   = '0;
    rx_idx    = '0;
    rx_on     = 1'b0;
  endtask

  // Advance the shadow link by one item; queue its beat if it has one. Return 0 if the item is ignored.
  function automatic bit predict_link(mode_e m, logic [7:0] a, logic [7:0] b,
                                      logic [15:0] w);
    res_t r;
    int   pos;
    int   sub;
    logic [7:0] d0, d1, d2;
    r = '0;
    case (m)
      MODE_LOAD: begin
        tx_bits = {a ^ b, b, a};
        tx_ph   = PH_PRE;
        tx_cnt  = '0;
        return 1'b1;
      end
      MODE_TICK: begin
        if (tx_ph == PH_PRE && tx_cnt >= 2 * cfg_pairs) begin
          tx_ph  = PH_HDR;
          tx_cnt = '0;
        end
        if (tx_ph == PH_HDR && tx_cnt >= cfg_hdr) begin
          tx_ph  = PH_DATA;
          tx_cnt = '0;
        end
        case (tx_ph)
          PH_PRE: begin
            r.toggle_line = 1'b1;
            tx_cnt = tx_cnt + 7'd1;
          end
          PH_HDR: begin
            r.toggle_line = 1'b0;
            tx_cnt = tx_cnt + 7'd1;
          end
          PH_DATA: begin
            sub = tx_cnt % 3;
            if (sub == 0) r.toggle_line = 1'b1;
            else if (sub == 1) r.toggle_line = tx_bits[0];
            else r.toggle_line = ~tx_bits[0];
            if (sub == 2) tx_bits = tx_bits >> 1;
            tx_cnt = tx_cnt + 7'd1;
            if (tx_cnt >= DATA_SLOTS) begin
              tx_ph  = PH_STOP;
              tx_cnt = '0;
            end
          end
          PH_STOP: begin
            r.toggle_line = (tx_cnt != 7'd1);
            tx_cnt = tx_cnt + 7'd1;
            if (tx_cnt >= STOP_SLOTS) begin
              r.tx_last = 1'b1;
              tx_ph     = PH_IDLE;
              tx_cnt    = '0;
            end
          end
          default: begin
            tx_ph = PH_IDLE;
            return 1'b0;
          end
        endcase
        pending_results.push_back(r);
        return 1'b1;
      end
      MODE_WIDTH: begin
        if (!rx_on) return 1'b0;
        if (rx_idx < cfg_skip) begin
          rx_idx = rx_idx + 8'd1;
          return 1'b1;
        end
        pos = rx_idx - cfg_skip;
        if (pos > LAST_BIT) pos = LAST_BIT;
        r.is_reply = 1'b1;
        if (fits_one(w)) begin
          rx_bits[pos] = 1'b1;
        end else if (!fits_zero(w)) begin
          rx_on       = 1'b0;
          r.rx_status = RX_BAD_WIDTH;
          pending_results.push_back(r);
          return 1'b1;
        end
        rx_idx = rx_idx + 8'd1;
        if (pos < LAST_BIT) return 1'b1;
        rx_on = 1'b0;
        d0 = rx_bits[7:0];
        d1 = rx_bits[15:8];
        d2 = rx_bits[23:16];
        if ((d0 ^ d1 ^ d2) != 8'h00) begin
          r.rx_status = RX_BAD_SUM;
        end else begin
          r.reply_first  = d0;
          r.reply_second = d1;
          r.rx_status    = RX_OK;
        end
        pending_results.push_back(r);
        return 1'b1;
      end
      default: begin
        rx_on   = 1'b1;
        rx_idx  = '0;
        rx_bits = '0;
        return 1'b1;
      end
    endcase
  endfunction

  // Offer one input beat, hold it until taken, then maybe idle.
  task automatic send_item(mode_e m, logic [7:0] a, logic [7:0] b, logic [15:0] w);
    int gap;
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    first_byte_i  <= a;
    second_byte_i <= b;
    pulse_width_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_link(m, a, b, w)) effective_items++;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_PREAMBLE_PAIRS: cfg_pairs = data[4:0];
      REG_HEADER_SLOTS:   cfg_hdr   = data[5:0];
      REG_BIT1_MIN:       one_lo    = data;
      REG_BIT1_MAX:       one_hi    = data;
      REG_BIT0_MIN:       zero_lo   = data;
      REG_BIT0_MAX:       zero_hi   = data;
      REG_SKIP_WIDTHS:    cfg_skip  = data[6:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_classes(logic [15:0] lo1, logic [15:0] hi1, logic [15:0] lo0,
                             logic [15:0] hi0);
    write_reg(REG_BIT1_MIN, lo1);
    write_reg(REG_BIT1_MAX, hi1);
    write_reg(REG_BIT0_MIN, lo0);
    write_reg(REG_BIT0_MAX, hi0);
  endtask

  task automatic tick_n(int n);
    repeat (n) send_item(MODE_TICK, 8'h00, 8'h00, 16'h0000);
  endtask

  task automatic tick_out_frame();
    do send_item(MODE_TICK, 8'h00, 8'h00, 16'h0000);
    while (tx_ph != PH_IDLE);
  endtask

  function automatic logic [15:0] width_for(bit v);
    logic [15:0] w;
    int k;
    if (v) return 16'($urandom_range(one_lo, one_hi));
    w = 16'($urandom_range(zero_lo, zero_hi));
    for (k = 0; k < 8 && fits_one(w); k++) w = 16'($urandom_range(zero_lo, zero_hi));
    return w;
  endfunction

  function automatic logic [15:0] width_outside();
    logic [15:0] w;
    int k;
    w = 16'($urandom);
    for (k = 0; k < 16 && (fits_one(w) || fits_zero(w)); k++) w = 16'($urandom);
    return w;
  endfunction

  // Plan skip widths plus one frame of bit widths, then begin receiving.
  task automatic start_reception(logic [7:0] a, logic [7:0] b, logic [7:0] c, int bad_at);
    logic [23:0] bits;
    int i;
    bits = {c, b, a};
    rx_plan_q.delete();
    repeat (cfg_skip) rx_plan_q.push_back(16'($urandom));
    for (i = 0; i < FRAME_BITS; i++)
      rx_plan_q.push_back(i == bad_at ? width_outside() : width_for(bits[i]));
    send_item(MODE_RECV, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic send_planned_width();
    send_item(MODE_WIDTH, 8'($urandom), 8'($urandom), rx_plan_q.pop_front());
    if (!rx_on) rx_plan_q.delete();
  endtask

  task automatic flush_reception();
    while (rx_plan_q.size() != 0) send_planned_width();
  endtask

  task automatic test_idle_items();
    send_item(MODE_TICK, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(MODE_WIDTH, 8'h00, 8'h00, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
  endtask

  task automatic test_tx_frames();
    send_item(MODE_LOAD, 8'h00, 8'hFF, 16'h0000);
    tick_out_frame();
    // empty preamble and header
    write_reg(REG_PREAMBLE_PAIRS, 16'h0000);
    write_reg(REG_HEADER_SLOTS, 16'h0000);
    send_item(MODE_LOAD, 8'hFF, 8'h00, 16'hFFFF);
    tick_out_frame();
    write_reg(REG_PREAMBLE_PAIRS, 16'hFFFF);
    write_reg(REG_HEADER_SLOTS, 16'hFFFF);
    send_item(MODE_LOAD, 8'h5A, 8'hC3, 16'h0000);
    tick_out_frame();
    // reload mid-frame: early, then inside the data bits
    write_reg(REG_PREAMBLE_PAIRS, 16'd2);
    write_reg(REG_HEADER_SLOTS, 16'd1);
    send_item(MODE_LOAD, 8'h12, 8'h34, 16'h0000);
    tick_n(4);
    send_item(MODE_LOAD, 8'hAB, 8'hCD, 16'h0000);
    tick_n(30);
    send_item(MODE_LOAD, 8'h80, 8'h01, 16'h0000);
    tick_out_frame();
    // shrink the preamble, then the header, below the slots already sent
    write_reg(REG_PREAMBLE_PAIRS, 16'd8);
    send_item(MODE_LOAD, 8'h96, 8'h69, 16'h0000);
    tick_n(10);
    write_reg(REG_PREAMBLE_PAIRS, 16'd2);
    tick_out_frame();
    write_reg(REG_PREAMBLE_PAIRS, 16'd0);
    write_reg(REG_HEADER_SLOTS, 16'd20);
    send_item(MODE_LOAD, 8'h3C, 8'hE1, 16'h0000);
    tick_n(8);
    write_reg(REG_HEADER_SLOTS, 16'd3);
    tick_out_frame();
  endtask

  task automatic test_rx_frames();
    set_classes(16'd100, 16'd199, 16'd200, 16'd299);
    write_reg(REG_SKIP_WIDTHS, 16'd0);
    start_reception(8'h3C, 8'h5A, 8'h66, -1);
    flush_reception();
    start_reception(8'h01, 8'h80, 8'h00, -1);
    flush_reception();
    start_reception(8'hFF, 8'hFF, 8'h00, 5);
    flush_reception();
    // restart while a reception is in flight
    write_reg(REG_SKIP_WIDTHS, 16'd20);
    start_reception(8'h77, 8'h11, 8'h66, -1);
    repeat (12) send_planned_width();
    start_reception(8'hA5, 8'h0F, 8'hAA, -1);
    flush_reception();
    // lower the skip count under the widths already taken
    start_reception(8'h11, 8'h22, 8'h33, -1);
    repeat (22) send_planned_width();
    write_reg(REG_SKIP_WIDTHS, 16'd0);
    flush_reception();
    write_reg(REG_SKIP_WIDTHS, 16'd40);
    start_reception(8'h44, 8'h88, 8'hCC, -1);
    repeat (50) send_planned_width();
    write_reg(REG_SKIP_WIDTHS, 16'd0);
    flush_reception();
    // every one width also fits the zero class
    set_classes(16'd200, 16'd250, 16'd200, 16'd299);
    write_reg(REG_SKIP_WIDTHS, 16'd3);
    start_reception(8'hC3, 8'h3C, 8'hFF, -1);
    flush_reception();
    set_classes(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    write_reg(REG_SKIP_WIDTHS, 16'hFFFF);
    start_reception(8'hFF, 8'h00, 8'hFF, -1);
    flush_reception();
    set_classes(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    write_reg(REG_SKIP_WIDTHS, 16'd1);
    start_reception(8'h0F, 8'hF0, 8'hFF, -1);
    flush_reception();
  endtask

  task automatic test_backpressure();
    write_reg(REG_PREAMBLE_PAIRS, 16'd4);
    write_reg(REG_HEADER_SLOTS, 16'd2);
    send_gaps_on = 1'b0;
    send_item(MODE_LOAD, 8'hC9, 8'h36, 16'h0000);
    // keep offering ticks while the receiver holds off
    hold_off_req = 1'b1;
    tick_n(40);
    wait_drained();
    tick_n(20);
    wait_drained();
    tick_out_frame();
    send_gaps_on = 1'b1;
  endtask

  task automatic randomize_config();
    int style;
    logic [15:0] lo1, hi1, lo0, hi0;
    style = $urandom_range(0, 19);
    write_reg(REG_PREAMBLE_PAIRS,
              {11'($urandom), 5'($urandom_range(0, 9) == 0 ? 31 : $urandom_range(0, 3))});
    write_reg(REG_HEADER_SLOTS,
              {10'($urandom), 6'($urandom_range(0, 9) == 0 ? 63 : $urandom_range(0, 5))});
    write_reg(REG_SKIP_WIDTHS,
              {9'($urandom), 7'($urandom_range(0, 11) == 0 ? 127 : $urandom_range(0, 24))});
    if (style < 7) begin
      lo1 = 16'($urandom_range(0, 1000));
      hi1 = 16'(lo1 + $urandom_range(0, 3000));
      lo0 = 16'(hi1 + 1 + $urandom_range(0, 500));
      hi0 = 16'(lo0 + $urandom_range(0, 3000));
    end else if (style < 14) begin
      lo0 = 16'($urandom_range(0, 1000));
      hi0 = 16'(lo0 + $urandom_range(0, 3000));
      lo1 = 16'(hi0 + 1 + $urandom_range(0, 500));
      hi1 = 16'(lo1 + $urandom_range(0, 3000));
    end else if (style < 17) begin
      lo1 = 16'($urandom_range(0, 2000));
      hi1 = 16'(lo1 + $urandom_range(100, 2000));
      lo0 = 16'($urandom_range(lo1, hi1));
      hi0 = 16'(lo0 + $urandom_range(0, 3000));
    end else begin
      lo1 = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
      hi1 = 16'($urandom);
      lo0 = 16'($urandom);
      hi0 = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
    end
    set_classes(lo1, hi1, lo0, hi0);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
  endtask

  // Interleave transmit frames and receptions, with a little noise.
  task automatic run_mixed(int n);
    int goal;
    int pick;
    logic [7:0] a, b;
    goal = effective_items + n;
    while (effective_items < goal) begin
      pick = $urandom_range(0, 99);
      a = 8'($urandom);
      b = 8'($urandom);
      if (pick < 4) begin
        send_item(mode_e'($urandom_range(0, 3)), a, b, 16'($urandom));
      end else if (pick < 52) begin
        if (tx_ph == PH_IDLE ? $urandom_range(0, 9) != 0 : $urandom_range(0, 199) == 0)
          send_item(MODE_LOAD, a, b, 16'($urandom));
        else
          send_item(MODE_TICK, a, b, 16'($urandom));
      end else if (rx_plan_q.size() == 0 || $urandom_range(0, 299) == 0) begin
        start_reception(a, b, $urandom_range(0, 6) == 0 ? 8'($urandom) : a ^ b,
                        $urandom_range(0, 11) == 0 ? $urandom_range(0, LAST_BIT) : -1);
      end else begin
        send_planned_width();
      end
    end
  endtask

  task automatic test_random();
    int ph;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      randomize_config();
      send_gaps_on = ($urandom_range(0, 3) != 0);
      rcv_gaps_on  = ($urandom_range(0, 3) != 0);
      run_mixed(RANDOM_ITEMS / RANDOM_PHASES);
    end
  endtask

  // Receiver: random stall runs, or a long hold-off on request.
  initial begin
    int stall_run;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!rcv_gaps_on) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        stall_run = pick_gap();
        if (stall_run > 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_run) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        failure_cnt++;
        if (failure_cnt <= REPORT_MAX)
          $display("%0t: unexpected beat reply=%0b tog=%0b last=%0b", $realtime,
                   is_reply_o, toggle_line_o, tx_last_o);
      end else begin
        want = pending_results.pop_front();
        if (want.is_reply !== is_reply_o || want.toggle_line !== toggle_line_o ||
            want.tx_last !== tx_last_o || want.reply_first !== reply_first_o ||
            want.reply_second !== reply_second_o || want.rx_status !== rx_status_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $write("%0t: mismatch exp reply=%0b tog=%0b last=%0b b0=%02h b1=%02h st=%0d",
                   $realtime, want.is_reply, want.toggle_line, want.tx_last,
                   want.reply_first, want.reply_second, want.rx_status);
            $display(" | got reply=%0b tog=%0b last=%0b b0=%02h b1=%02h st=%0d",
                     is_reply_o, toggle_line_o, tx_last_o, reply_first_o,
                     reply_second_o, rx_status_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_valid_i      = 1'b0;
    mode_i          = MODE_LOAD;
    first_byte_i    = '0;
    second_byte_i   = '0;
    pulse_width_i   = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    mismatch_cnt    = 0;
    failure_cnt     = 0;
    effective_items = 0;
    send_gaps_on    = 1'b1;
    rcv_gaps_on     = 1'b1;
    hold_off_req    = 1'b0;
    rst_ni          = 1'b0;
    reset_predictor();
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_items();
    test_tx_frames();
    test_rx_frames();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatch_cnt == 0 && failure_cnt == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
